// ===== rtl/rpa_pkg.sv =====
// Shared types, codes and sizes for the reference-counted page allocator.
// No dependencies; every other file of the block refers to this package.
package rpa_pkg;

  localparam int PAGE_COUNT  = 32768;
  localparam int COUNT_BITS  = 8;
  localparam int PAGE_W      = 15;
  localparam int IDX_W       = $clog2(PAGE_COUNT);
  localparam int TOP_W       = $clog2(PAGE_COUNT) + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_FREE    = 3'd1;
  localparam logic [2:0] MODE_INC     = 3'd2;
  localparam logic [2:0] MODE_RESOLVE = 3'd3;
  localparam logic [2:0] MODE_QUERY   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [2:0] {
    OPK_ALLOC,
    OPK_FREE,
    OPK_INC,
    OPK_RESOLVE,
    OPK_QUERY,
    OPK_RANGE,
    OPK_NOP
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_FIX
  } bk_state_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [PAGE_W-1:0] page;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PAGE_W-1:0]     result_page;
    logic                  copy_needed;
    logic                  page_released;
    logic [COUNT_BITS-1:0] ref_count;
  } rsp_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [PAGE_W-1:0] page;
  } op_t;

endpackage

// ===== rtl/rpa_front.sv =====
// Front end: configuration register, range check and request classification.
// Depends on rpa_pkg.
module rpa_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rpa_pkg::PAGE_W-1:0] cfg_data,
  input  logic                       push,
  input  rpa_pkg::req_t              req,
  input  logic                       q_full,
  input  logic                       clearing,
  output logic                       full,
  output logic                       q_push,
  output rpa_pkg::op_t               q_entry
);

  logic [rpa_pkg::PAGE_W-1:0] first_usable_page;
  logic                       in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable_page <= '0;
    end else if (cfg_we) begin
      first_usable_page <= cfg_data;
    end
  end

  assign full   = q_full | clearing;
  assign q_push = push & ~full;

  assign in_range = (req.page >= first_usable_page) &&
                    (32'(req.page) < rpa_pkg::PAGE_COUNT);

  always_comb begin
    q_entry.page = req.page;
    case (req.mode)
      rpa_pkg::MODE_ALLOC:   q_entry.kind = rpa_pkg::OPK_ALLOC;
      rpa_pkg::MODE_FREE:    q_entry.kind = in_range ? rpa_pkg::OPK_FREE : rpa_pkg::OPK_RANGE;
      rpa_pkg::MODE_INC:     q_entry.kind = in_range ? rpa_pkg::OPK_INC : rpa_pkg::OPK_RANGE;
      rpa_pkg::MODE_RESOLVE: q_entry.kind = in_range ? rpa_pkg::OPK_RESOLVE
                                                     : rpa_pkg::OPK_RANGE;
      rpa_pkg::MODE_QUERY:   q_entry.kind = in_range ? rpa_pkg::OPK_QUERY : rpa_pkg::OPK_RANGE;
      default:               q_entry.kind = rpa_pkg::OPK_NOP;
    endcase
  end

endmodule

// ===== rtl/rpa_queue.sv =====
// Short first-in-first-out queue of classified operations between front and back.
// Depends on rpa_pkg.
module rpa_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  rpa_pkg::op_t wr_data,
  input  logic         rd_en,
  output rpa_pkg::op_t rd_data,
  output logic         q_full,
  output logic         q_empty
);

  rpa_pkg::op_t                 slots [rpa_pkg::QUEUE_DEPTH];
  logic [rpa_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rpa_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rpa_pkg::QCNT_W-1:0]   fill;

  assign q_full  = (fill == rpa_pkg::QCNT_W'(rpa_pkg::QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (32'(wr_ptr) == rpa_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (32'(rd_ptr) == rpa_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/rpa_back.sv =====
// Back end: count memory, free stack memory, sequencer and result register.
// Depends on rpa_pkg.
module rpa_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  rpa_pkg::op_t q_head,
  output logic         q_pop,
  output logic         clearing,
  output logic         rsp_valid,
  output rpa_pkg::rsp_t rsp,
  input  logic         pop
);

  localparam logic [rpa_pkg::TOP_W-1:0] TOP_FULL = rpa_pkg::TOP_W'(rpa_pkg::PAGE_COUNT);

  logic [rpa_pkg::COUNT_BITS-1:0] count_mem [rpa_pkg::PAGE_COUNT];
  logic [rpa_pkg::PAGE_W-1:0]     stack_mem [rpa_pkg::PAGE_COUNT];

  rpa_pkg::bk_state_t             state, state_next;
  logic [rpa_pkg::TOP_W-1:0]      top, top_next;
  logic [rpa_pkg::IDX_W-1:0]      clr, clr_next;
  rpa_pkg::op_t                   op, op_next;
  logic [rpa_pkg::COUNT_BITS-1:0] fix_cnt, fix_cnt_next;
  logic                           rsp_load;
  rpa_pkg::rsp_t                  rsp_next;

  logic                           cnt_we;
  logic [rpa_pkg::IDX_W-1:0]      cnt_waddr, cnt_raddr;
  logic [rpa_pkg::COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                           stk_we;
  logic [rpa_pkg::IDX_W-1:0]      stk_waddr, stk_raddr;
  logic [rpa_pkg::PAGE_W-1:0]     stk_wdata, stk_rdata;

  logic [rpa_pkg::TOP_W-1:0]      top_dec;
  logic [rpa_pkg::COUNT_BITS-1:0] old_dec, old_inc;
  logic                           have_page, can_push, same_page;
  logic [rpa_pkg::IDX_W-1:0]      op_idx, np_idx;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= count_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stack_mem[stk_raddr];
  end

  assign top_dec   = top - 1'b1;
  assign cnt_raddr = q_head.page[rpa_pkg::IDX_W-1:0];
  assign stk_raddr = top_dec[rpa_pkg::IDX_W-1:0];
  assign op_idx    = op.page[rpa_pkg::IDX_W-1:0];
  assign np_idx    = stk_rdata[rpa_pkg::IDX_W-1:0];
  assign old_dec   = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;
  assign old_inc   = (cnt_rdata != rpa_pkg::COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
  assign have_page = (top != '0);
  assign can_push  = (top != TOP_FULL);
  assign same_page = (np_idx == op_idx);
  assign clearing  = (state == rpa_pkg::BK_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpa_pkg::BK_CLEAR;
      top       <= '0;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      top   <= top_next;
      clr   <= clr_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (pop) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    fix_cnt <= fix_cnt_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next   = state;
    top_next     = top;
    clr_next     = clr;
    op_next      = op;
    fix_cnt_next = fix_cnt;
    q_pop        = 1'b0;
    cnt_we       = 1'b0;
    cnt_waddr    = op_idx;
    cnt_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = top[rpa_pkg::IDX_W-1:0];
    stk_wdata    = op.page;
    rsp_load     = 1'b0;
    rsp_next     = '0;

    case (state)
      rpa_pkg::BK_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == '1) begin
          state_next = rpa_pkg::BK_IDLE;
        end
      end

      rpa_pkg::BK_IDLE: begin
        if (!q_empty && (!rsp_valid || pop)) begin
          q_pop      = 1'b1;
          op_next    = q_head;
          state_next = rpa_pkg::BK_EXEC;
        end
      end

      rpa_pkg::BK_EXEC: begin
        rsp_load   = 1'b1;
        state_next = rpa_pkg::BK_IDLE;
        case (op.kind)
          rpa_pkg::OPK_ALLOC: begin
            if (have_page) begin
              top_next             = top_dec;
              cnt_we               = 1'b1;
              cnt_waddr            = np_idx;
              cnt_wdata            = rpa_pkg::COUNT_BITS'(1);
              rsp_next.result_page = stk_rdata;
              rsp_next.ref_count   = rpa_pkg::COUNT_BITS'(1);
            end else begin
              rsp_next.status = rpa_pkg::ST_NO_FREE;
            end
          end
          rpa_pkg::OPK_FREE: begin
            cnt_we             = 1'b1;
            cnt_wdata          = old_dec;
            rsp_next.ref_count = old_dec;
            if (old_dec == '0 && can_push) begin
              stk_we                 = 1'b1;
              top_next               = top + 1'b1;
              rsp_next.page_released = 1'b1;
            end
          end
          rpa_pkg::OPK_INC: begin
            cnt_we             = 1'b1;
            cnt_wdata          = old_inc;
            rsp_next.ref_count = old_inc;
          end
          rpa_pkg::OPK_RESOLVE: begin
            if (cnt_rdata == rpa_pkg::COUNT_BITS'(1)) begin
              rsp_next.result_page = op.page;
              rsp_next.ref_count   = cnt_rdata;
            end else if (have_page) begin
              top_next             = top_dec;
              rsp_next.result_page = stk_rdata;
              rsp_next.copy_needed = 1'b1;
              cnt_we               = 1'b1;
              if (same_page) begin
                // Popped the named page itself: set to one, then drop to zero.
                cnt_wdata          = '0;
                rsp_next.ref_count = '0;
              end else begin
                cnt_waddr          = np_idx;
                cnt_wdata          = rpa_pkg::COUNT_BITS'(1);
                fix_cnt_next       = old_dec;
                rsp_next.ref_count = old_dec;
                state_next         = rpa_pkg::BK_FIX;
              end
            end else begin
              rsp_next.status    = rpa_pkg::ST_NO_FREE;
              rsp_next.ref_count = cnt_rdata;
            end
          end
          rpa_pkg::OPK_QUERY: begin
            rsp_next.ref_count = cnt_rdata;
          end
          rpa_pkg::OPK_RANGE: begin
            rsp_next.status = rpa_pkg::ST_RANGE;
          end
          default: begin
            rsp_next = '0;
          end
        endcase
      end

      rpa_pkg::BK_FIX: begin
        cnt_we     = 1'b1;
        cnt_wdata  = fix_cnt;
        state_next = rpa_pkg::BK_IDLE;
      end

      default: begin
        state_next = rpa_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// Reference-counted page allocator, top level: front end, queue and back end.
// A request passes the queue and the back end's idle and exec states, exec loading
// the result register. The next is taken once that register is free or popped; a
// resolve giving a page other than the named one also passes the fix state, the
// count memory having one write port. Reset: synchronous; then all 32768 count
// entries are cleared one a cycle, full held high; configuration writes are taken.
module refcounted_page_allocator (
  input  logic                       clk,
  input  logic                       rst,
  // Request side, queue style: transaction on push while not full.
  input  logic                       push,
  output logic                       full,
  input  rpa_pkg::req_t              req,
  // Result side, queue style: transaction on pop while not empty.
  output logic                       empty,
  input  logic                       pop,
  output rpa_pkg::rsp_t              rsp,
  // Configuration: lowest page number requests may name.
  input  logic                       cfg_we,
  input  logic [rpa_pkg::PAGE_W-1:0] cfg_data
);

  logic          q_push, q_pop, q_full, q_empty;
  logic          clearing, rsp_valid;
  rpa_pkg::op_t  q_entry, q_head;

  // Classify each request (range check, mode decode) as it is accepted.
  rpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .req      (req),
    .q_full   (q_full),
    .clearing (clearing),
    .full     (full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // Hold classified operations so the front keeps taking requests while the
  // back end is busy or the result register waits on pop.
  rpa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Read counts and stack top as an operation is taken, update memories and
  // load the result register in the next cycle; a resolve copying to a page
  // other than the named one then passes the fix state for the old page's count.
  rpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .pop       (pop)
  );

  assign empty = ~rsp_valid;

endmodule

// ===== rtl/rpa_checker.sv =====
// Port-level checks on the page allocator, attached to the top level by bind.
// Depends on rpa_pkg and refcounted_page_allocator.
module rpa_checker (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input rpa_pkg::rsp_t rsp
);

  // Hold a waiting result until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("result changed while waiting");

  // Block requests right after reset, as the count clearing pass begins.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> full)
    else $error("request side open right after reset");

  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.status == rpa_pkg::ST_RANGE) |->
      (rsp.result_page == '0 && !rsp.copy_needed && !rsp.page_released &&
       rsp.ref_count == '0))
    else $error("range error carries data");

  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.copy_needed) |->
      (rsp.status == rpa_pkg::ST_OK && !rsp.page_released))
    else $error("copy flagged on failed or free transaction");

  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.page_released) |->
      (rsp.status == rpa_pkg::ST_OK && rsp.ref_count == '0 && rsp.result_page == '0))
    else $error("page released with nonzero count");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .rsp   (rsp)
);
